// ----- rtl/qrtc_pkg.sv -----
// ----------------------------------------------------------------------------
// qrtc_pkg
// Types and constants shared by the query/retry transaction controller.
// ----------------------------------------------------------------------------
package qrtc_pkg;

  localparam logic [15:0] RESP_TIMEOUT_RESET = 16'd1500;
  localparam logic [15:0] RETRY_DELAY_RESET  = 16'd500;
  localparam logic [15:0] READY_DELAY_RESET  = 16'd300;
  localparam logic [3:0]  MAX_ATTEMPTS_RESET = 4'd4;
  localparam logic [7:0]  VOL_MAX            = 8'd100;

  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_QUERY    = 3'd1,
    CMD_SET      = 3'd2,
    CMD_READY    = 3'd3,
    CMD_RESPONSE = 3'd4,
    CMD_CANCEL   = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_RESP_TIMEOUT = 2'd0,
    CFG_RETRY_DELAY  = 2'd1,
    CFG_READY_DELAY  = 2'd2,
    CFG_MAX_ATTEMPTS = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_WAIT_SEND = 2'd1,
    PH_WAIT_RESP = 2'd2
  } phase_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] settle_delay;
    logic [7:0]  volume;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] assigned_id;
    logic        send_query;
    logic        send_set;
    logic [6:0]  set_value;
    logic [3:0]  attempt_number;
    logic        event_valid;
    logic        event_timeout;
    logic [31:0] event_id;
    logic [6:0]  event_volume;
    logic [31:0] ready_count;
  } rsp_t;

  typedef struct packed {
    logic [15:0] response_timeout_ms;
    logic [15:0] retry_delay_ms;
    logic [15:0] ready_delay_ms;
    logic [3:0]  max_attempts;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_time;
    phase_t      phase;
    logic [31:0] active_id;
    logic [31:0] next_id;
    logic [31:0] due_time;
    logic [31:0] sent_time;
    logic [3:0]  attempts;
    logic        set_pending;
    logic [6:0]  set_hold;
    logic [31:0] ready_gen;
  } ctl_state_t;

endpackage

// ----- rtl/qrtc_step.sv -----
// ----------------------------------------------------------------------------
// qrtc_step
// Next-state and result logic for one request applied to the controller state.
// ----------------------------------------------------------------------------
module qrtc_step
  import qrtc_pkg::*;
(
  input  ctl_state_t st,
  input  cfg_t       cfg,
  input  req_t       req,
  output ctl_state_t st_next,
  output rsp_t       res
);

  logic [31:0] now_inc;
  logic [31:0] since_due;
  logic [31:0] since_sent;
  logic        due_reached;
  logic        resp_timed_out;
  logic        can_retry;
  logic [31:0] gen_inc;
  logic [31:0] gen_next;
  logic [31:0] id_inc;
  logic [6:0]  set_clamped;
  logic        resp_taken;

  assign now_inc        = st.now_time + 32'd1;
  assign since_due      = now_inc - st.due_time;
  assign since_sent     = now_inc - st.sent_time;
  // wrap-safe: reached when the difference is not negative
  assign due_reached    = ~since_due[31];
  assign resp_timed_out = since_sent >= {16'd0, cfg.response_timeout_ms};
  assign can_retry      = st.attempts < cfg.max_attempts;
  assign gen_inc        = st.ready_gen + 32'd1;
  assign gen_next       = (gen_inc == 32'd0) ? 32'd1 : gen_inc;
  assign id_inc         = st.next_id + 32'd1;
  assign set_clamped    = (req.volume > VOL_MAX) ? VOL_MAX[6:0] : req.volume[6:0];
  assign resp_taken     = (req.volume <= VOL_MAX) && (st.active_id != 32'd0) &&
                          ((st.phase == PH_WAIT_RESP) ||
                           ((st.phase == PH_WAIT_SEND) && (st.attempts != 4'd0)));

  // next state
  always_comb begin
    st_next = st;
    unique case (req.cmd)
      CMD_TICK: begin
        st_next.now_time = now_inc;
        if (st.set_pending) begin
          st_next.set_pending = 1'b0;
        end else if (st.phase == PH_WAIT_SEND && due_reached) begin
          st_next.attempts  = st.attempts + 4'd1;
          st_next.sent_time = now_inc;
          st_next.phase     = PH_WAIT_RESP;
        end else if (st.phase == PH_WAIT_RESP && resp_timed_out) begin
          if (can_retry) begin
            st_next.phase    = PH_WAIT_SEND;
            st_next.due_time = now_inc + {16'd0, cfg.retry_delay_ms};
          end else begin
            st_next.phase     = PH_IDLE;
            st_next.active_id = 32'd0;
            st_next.due_time  = 32'd0;
            st_next.sent_time = 32'd0;
            st_next.attempts  = 4'd0;
          end
        end
      end
      CMD_QUERY: begin
        if (!st.set_pending) begin
          st_next.active_id = st.next_id;
          st_next.next_id   = (id_inc == 32'd0) ? 32'd1 : id_inc;
          st_next.phase     = PH_WAIT_SEND;
          st_next.due_time  = st.now_time + {16'd0, req.settle_delay};
          st_next.sent_time = 32'd0;
          st_next.attempts  = 4'd0;
        end
      end
      CMD_SET: begin
        st_next.phase       = PH_IDLE;
        st_next.active_id   = 32'd0;
        st_next.due_time    = 32'd0;
        st_next.sent_time   = 32'd0;
        st_next.attempts    = 4'd0;
        st_next.set_hold    = set_clamped;
        st_next.set_pending = 1'b1;
      end
      CMD_READY: begin
        st_next.ready_gen = gen_next;
        if (st.active_id != 32'd0) begin
          if (st.phase == PH_WAIT_SEND ||
              (st.phase == PH_WAIT_RESP && can_retry)) begin
            st_next.phase    = PH_WAIT_SEND;
            st_next.due_time = st.now_time + {16'd0, cfg.ready_delay_ms};
          end
        end
      end
      CMD_RESPONSE: begin
        if (resp_taken) begin
          st_next.phase     = PH_IDLE;
          st_next.active_id = 32'd0;
          st_next.due_time  = 32'd0;
          st_next.sent_time = 32'd0;
          st_next.attempts  = 4'd0;
        end
      end
      CMD_CANCEL: begin
        st_next.phase     = PH_IDLE;
        st_next.active_id = 32'd0;
        st_next.due_time  = 32'd0;
        st_next.sent_time = 32'd0;
        st_next.attempts  = 4'd0;
      end
      default: begin
        st_next = st;
      end
    endcase
  end

  // result
  always_comb begin
    res             = '0;
    res.ready_count = st_next.ready_gen;
    unique case (req.cmd)
      CMD_TICK: begin
        if (st.set_pending) begin
          res.send_set  = 1'b1;
          res.set_value = st.set_hold;
        end else if (st.phase == PH_WAIT_SEND && due_reached) begin
          res.send_query     = 1'b1;
          res.attempt_number = st.attempts + 4'd1;
        end else if (st.phase == PH_WAIT_RESP && resp_timed_out && !can_retry) begin
          res.event_valid   = 1'b1;
          res.event_timeout = 1'b1;
          res.event_id      = st.active_id;
        end
      end
      CMD_QUERY: begin
        if (!st.set_pending) begin
          res.accepted    = 1'b1;
          res.assigned_id = st.next_id;
        end
      end
      CMD_SET: begin
        res.accepted = 1'b1;
      end
      CMD_RESPONSE: begin
        if (resp_taken) begin
          res.accepted     = 1'b1;
          res.event_valid  = 1'b1;
          res.event_id     = st.active_id;
          res.event_volume = req.volume[6:0];
        end
      end
      CMD_READY, CMD_CANCEL: begin
        res.accepted = 1'b0;
      end
      default: begin
        res.accepted = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/query_retry_transaction_controller.sv -----
// ----------------------------------------------------------------------------
// query_retry_transaction_controller
// Drives one volume query transaction to a serial module, with retry on
// response timeout, re-arm on module ready and priority for set requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests (ticks, query, set, module ready, response, cancel) enter on
//   req_valid / req_stall / req. Every request yields exactly one result on
//   rsp_valid / rsp_stall / rsp, in order.
//   The controller state updates in the cycle a request is taken; the result
//   sits in an output register and is shown the next cycle.
//   Throughput is one request per cycle: a new request is taken while the
//   previous result is being taken. If the receiver stalls with a result
//   held, req_stall rises and the held result stays unchanged.
//   Registers are to be written through cfg_we / cfg_index / cfg_data only
//   while no request is in flight; the block itself does not enforce this.
//   Synchronous reset loads the register defaults (timeout 1500 ms, retry
//   500 ms, ready 300 ms, 4 attempts), clears the transaction, sets the
//   next id to one and empties the output register.
// ----------------------------------------------------------------------------
module query_retry_transaction_controller
  import qrtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_index,
  input  logic [15:0] cfg_data
);

  localparam ctl_state_t ST_RESET = '{
    now_time:    32'd0,
    phase:       PH_IDLE,
    active_id:   32'd0,
    next_id:     32'd1,
    due_time:    32'd0,
    sent_time:   32'd0,
    attempts:    4'd0,
    set_pending: 1'b0,
    set_hold:    7'd0,
    ready_gen:   32'd0
  };

  cfg_t       cfg;
  ctl_state_t st;
  ctl_state_t st_next;
  rsp_t       res;
  logic       take;

  assign req_stall = rsp_valid && rsp_stall;
  assign take      = req_valid && !req_stall;

  qrtc_step u_step (
    .st      (st),
    .cfg     (cfg),
    .req     (req),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.response_timeout_ms <= RESP_TIMEOUT_RESET;
      cfg.retry_delay_ms      <= RETRY_DELAY_RESET;
      cfg.ready_delay_ms      <= READY_DELAY_RESET;
      cfg.max_attempts        <= MAX_ATTEMPTS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RESP_TIMEOUT: cfg.response_timeout_ms <= cfg_data;
        CFG_RETRY_DELAY:  cfg.retry_delay_ms      <= cfg_data;
        CFG_READY_DELAY:  cfg.ready_delay_ms      <= cfg_data;
        CFG_MAX_ATTEMPTS: cfg.max_attempts        <= cfg_data[3:0];
        default:          cfg.max_attempts        <= cfg.max_attempts;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else if (take) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp <= res;
    end
  end

endmodule

// ----- dv/tb_query_retry_transaction_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_query_retry_transaction_controller
// Self-checking bench for the query/retry transaction controller. A directed
// run of events covers the corner cases, then random query transactions mixed
// with noise run under several register settings and random gaps on both
// sides. Every result is checked field by field against a local model.
// ----------------------------------------------------------------------------
module tb_query_retry_transaction_controller;
  import qrtc_pkg::*;

  // command codes the block does not decode
  localparam logic [2:0] CMD_UNUSED_A = 3'd6;
  localparam logic [2:0] CMD_UNUSED_B = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  logic        cfg_we = 1'b0;
  cfg_idx_t    cfg_index = CFG_RESP_TIMEOUT;
  logic [15:0] cfg_data = '0;

  query_retry_transaction_controller dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  req_t        pending_requests[$];
  rsp_t        expected_results[$];
  int unsigned send_idle_pct = 26;
  int unsigned recv_idle_pct = 83;
  int unsigned err_cnt = 0;
  int unsigned requests_taken = 0;
  int unsigned results_checked = 0;
  int unsigned queries_sent = 0;
  int unsigned sets_sent = 0;
  int unsigned success_events = 0;
  int unsigned timeout_events = 0;

  // controller model: registers and transaction state
  logic [15:0] resp_to;
  logic [15:0] retry_dly;
  logic [15:0] ready_dly;
  logic [3:0]  max_tries;
  logic [31:0] clk_ms;
  phase_t      txn_phase;
  logic [31:0] txn_id;
  logic [31:0] id_next;
  logic [31:0] due_ms;
  logic [31:0] sent_ms;
  logic [3:0]  tries;
  logic        set_waiting;
  logic [6:0]  set_vol;
  logic [31:0] ready_cnt;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void drop_query();
    txn_phase = PH_IDLE;
    txn_id    = '0;
    due_ms    = '0;
    sent_ms   = '0;
    tries     = '0;
  endfunction

  function automatic rsp_t predict_result(req_t r);
    rsp_t        o;
    logic [31:0] lag;
    logic [7:0]  vol;
    o   = '0;
    vol = r.volume;
    case (r.cmd)
      CMD_TICK: begin
        clk_ms = clk_ms + 32'd1;
        lag    = clk_ms - due_ms;
        if (set_waiting) begin
          set_waiting = 1'b0;
          o.send_set  = 1'b1;
          o.set_value = set_vol;
        end else if (txn_phase == PH_WAIT_SEND && !lag[31]) begin
          tries            = tries + 4'd1;
          sent_ms          = clk_ms;
          txn_phase        = PH_WAIT_RESP;
          o.send_query     = 1'b1;
          o.attempt_number = tries;
        end else if (txn_phase == PH_WAIT_RESP && (clk_ms - sent_ms) >= {16'd0, resp_to}) begin
          if (tries < max_tries) begin
            txn_phase = PH_WAIT_SEND;
            due_ms    = clk_ms + {16'd0, retry_dly};
          end else begin
            o.event_valid   = 1'b1;
            o.event_timeout = 1'b1;
            o.event_id      = txn_id;
            drop_query();
          end
        end
      end
      CMD_QUERY: begin
        if (!set_waiting) begin
          o.accepted    = 1'b1;
          o.assigned_id = id_next;
          txn_id        = id_next;
          id_next       = id_next + 32'd1;
          if (id_next == '0) id_next = 32'd1;
          txn_phase = PH_WAIT_SEND;
          due_ms    = clk_ms + {16'd0, r.settle_delay};
          sent_ms   = '0;
          tries     = '0;
        end
      end
      CMD_SET: begin
        if (vol > VOL_MAX) vol = VOL_MAX;
        drop_query();
        set_vol     = vol[6:0];
        set_waiting = 1'b1;
        o.accepted  = 1'b1;
      end
      CMD_READY: begin
        ready_cnt = ready_cnt + 32'd1;
        if (ready_cnt == '0) ready_cnt = 32'd1;
        if (txn_id != '0) begin
          if (txn_phase == PH_WAIT_SEND) begin
            due_ms = clk_ms + {16'd0, ready_dly};
          end else if (txn_phase == PH_WAIT_RESP && tries < max_tries) begin
            txn_phase = PH_WAIT_SEND;
            due_ms    = clk_ms + {16'd0, ready_dly};
          end
        end
      end
      CMD_RESPONSE: begin
        // taken while awaiting a response, or between retries once a query went out
        if (vol <= VOL_MAX && txn_id != '0 &&
            (txn_phase == PH_WAIT_RESP || (txn_phase == PH_WAIT_SEND && tries != '0))) begin
          o.accepted     = 1'b1;
          o.event_valid  = 1'b1;
          o.event_id     = txn_id;
          o.event_volume = vol[6:0];
          drop_query();
        end
      end
      CMD_CANCEL: drop_query();
      default: ;
    endcase
    o.ready_count = ready_cnt;
    return o;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, got_val);
      err_cnt++;
    end
  endtask

  task automatic check_result(rsp_t exp_r, rsp_t got_r);
    check_field("accepted", 32'(exp_r.accepted), 32'(got_r.accepted));
    check_field("assigned_id", exp_r.assigned_id, got_r.assigned_id);
    check_field("send_query", 32'(exp_r.send_query), 32'(got_r.send_query));
    check_field("send_set", 32'(exp_r.send_set), 32'(got_r.send_set));
    check_field("set_value", 32'(exp_r.set_value), 32'(got_r.set_value));
    check_field("attempt_number", 32'(exp_r.attempt_number), 32'(got_r.attempt_number));
    check_field("event_valid", 32'(exp_r.event_valid), 32'(got_r.event_valid));
    check_field("event_timeout", 32'(exp_r.event_timeout), 32'(got_r.event_timeout));
    check_field("event_id", exp_r.event_id, got_r.event_id);
    check_field("event_volume", 32'(exp_r.event_volume), 32'(got_r.event_volume));
    check_field("ready_count", exp_r.ready_count, got_r.ready_count);
    results_checked++;
    if (got_r.send_query) queries_sent++;
    if (got_r.send_set) sets_sent++;
    if (got_r.event_valid && got_r.event_timeout) timeout_events++;
    if (got_r.event_valid && !got_r.event_timeout) success_events++;
  endtask

  // request driver: model updates at the edge a request is taken
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        expected_results.push_back(predict_result(req));
        requests_taken++;
      end
      if (!req_valid || !req_stall) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_valid <= 1'b1;
          req       <= pending_requests.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: %p", rsp);
          err_cnt++;
        end else begin
          check_result(expected_results.pop_front(), rsp);
        end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic push_item(logic [2:0] c, logic [15:0] settle, logic [7:0] vol);
    req_t r;
    r.cmd          = cmd_t'(c);
    r.settle_delay = settle;
    r.volume       = vol;
    pending_requests.push_back(r);
  endtask

  task automatic push_ticks(int unsigned n);
    repeat (n) push_item(CMD_TICK, 16'($urandom), 8'($urandom));
  endtask

  function automatic logic [15:0] rand_settle();
    if ($urandom_range(7) == 0) return 16'($urandom);
    return 16'($urandom_range(6));
  endfunction

  function automatic logic [7:0] rand_volume();
    if ($urandom_range(9) == 0) return 8'($urandom);
    return 8'($urandom_range(100));
  endfunction

  // wait until every request is taken and every result has come back
  task automatic drain();
    do @(posedge clk);
    while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] to, logic [15:0] retry, logic [15:0] rdy,
                          logic [3:0] tries_max);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RESP_TIMEOUT;
    cfg_data  <= to;
    resp_to   = to;
    @(posedge clk);
    cfg_index <= CFG_RETRY_DELAY;
    cfg_data  <= retry;
    retry_dly = retry;
    @(posedge clk);
    cfg_index <= CFG_READY_DELAY;
    cfg_data  <= rdy;
    ready_dly = rdy;
    @(posedge clk);
    // upper data bits are don't-care for the attempt limit
    cfg_index <= CFG_MAX_ATTEMPTS;
    cfg_data  <= {12'($urandom), tries_max};
    max_tries = tries_max;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly well-formed query transactions with random timing, plus noise
  task automatic add_traffic(int unsigned n);
    int unsigned start;
    start = pending_requests.size();
    while (pending_requests.size() - start < n) begin
      if ($urandom_range(99) < 60) begin
        push_item(CMD_QUERY, rand_settle(), 8'($urandom));
        push_ticks($urandom_range(1, 10));
        if ($urandom_range(3) == 0) begin
          push_item(CMD_READY, 16'($urandom), 8'($urandom));
          push_ticks($urandom_range(0, 6));
        end
        if ($urandom_range(9) < 7) push_item(CMD_RESPONSE, 16'($urandom), rand_volume());
        push_ticks($urandom_range(1, 2));
      end else begin
        push_item(3'($urandom_range(7)), rand_settle(), 8'($urandom));
      end
    end
  endtask

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    resp_to     = RESP_TIMEOUT_RESET;
    retry_dly   = RETRY_DELAY_RESET;
    ready_dly   = READY_DELAY_RESET;
    max_tries   = MAX_ATTEMPTS_RESET;
    clk_ms      = '0;
    txn_phase   = PH_IDLE;
    txn_id      = '0;
    id_next     = 32'd1;
    due_ms      = '0;
    sent_ms     = '0;
    tries       = '0;
    set_waiting = 1'b0;
    set_vol     = '0;
    ready_cnt   = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed corner cases
    set_regs(16'd2, 16'd1, 16'd0, 4'd2);
    push_item(CMD_TICK, 16'h0000, 8'h00);
    push_item(CMD_UNUSED_A, 16'hFFFF, 8'hFF);
    push_item(CMD_UNUSED_B, 16'h5A5A, 8'hA5);
    push_item(CMD_RESPONSE, 16'h0000, 8'd50);    // nothing waiting
    push_item(CMD_QUERY, 16'h0000, 8'h00);
    push_item(CMD_TICK, 16'h0000, 8'h00);        // first send
    push_item(CMD_RESPONSE, 16'h0000, 8'hFF);    // out of range, ignored
    push_ticks(2);                                // timeout, retry armed
    push_item(CMD_RESPONSE, 16'h0000, 8'd100);   // late response between retries
    push_item(CMD_QUERY, 16'hFFFF, 8'h00);
    push_item(CMD_QUERY, 16'h0001, 8'h00);       // replaces the active query
    push_item(CMD_READY, 16'h0000, 8'h00);       // re-arm while waiting to send
    push_item(CMD_TICK, 16'h0000, 8'h00);
    push_item(CMD_READY, 16'h0000, 8'h00);       // re-arm while awaiting response
    push_ticks(3);                                // second send, then give up
    push_item(CMD_SET, 16'h0000, 8'hFF);         // clamped
    push_item(CMD_QUERY, 16'h0000, 8'h00);       // rejected, set pending
    push_item(CMD_SET, 16'h0000, 8'h00);         // latest value wins
    push_item(CMD_TICK, 16'h0000, 8'h00);
    push_item(CMD_CANCEL, 16'hFFFF, 8'hFF);
    push_item(CMD_RESPONSE, 16'h0000, 8'h00);
    push_item(CMD_TICK, 16'hFFFF, 8'hFF);
    drain();

    // sender idles lightly, receiver heavily
    set_regs(16'd1, 16'd0, 16'd0, 4'd1);
    add_traffic(150);
    drain();   // hold off the sender until everything has come back
    add_traffic(150);
    drain();
    set_regs(16'd3, 16'd2, 16'd1, 4'd0);
    add_traffic(300);
    drain();

    send_idle_pct = 83;
    recv_idle_pct = 26;
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15);
    add_traffic(300);
    drain();
    set_regs(16'd5, 16'd3, 16'd2, 4'd15);
    add_traffic(300);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_regs(16'd2, 16'd1, 16'd4, 4'd3);
    add_traffic(300);
    drain();
    set_regs(16'($urandom_range(1, 6)), 16'($urandom_range(4)), 16'($urandom_range(4)),
             4'($urandom_range(15)));
    add_traffic(300);
    drain();
    repeat (5) @(posedge clk);

    $display("%0d requests taken, %0d results checked under 7 register settings",
             requests_taken, results_checked);
    $display("%0d queries sent, %0d sets sent, %0d responses matched, %0d timeouts",
             queries_sent, sets_sent, success_events, timeout_events);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- query_retry_transaction_controller.f -----
rtl/qrtc_pkg.sv
rtl/qrtc_step.sv
rtl/query_retry_transaction_controller.sv
dv/tb_query_retry_transaction_controller.sv
